/* hdl/kdlpr_pkg.sv */
// Shared types and constants for the key debounce / long press / repeat block.
// Used by kdlpr_step and key_debounce_long_press_repeat. No dependencies.
package kdlpr_pkg;

  // Per-key phase codes; codes 6 and 7 are unused and behave as start.
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_CONFIRM = 3'd1,
    PH_DOWN    = 3'd2,
    PH_LONG    = 3'd3,
    PH_REPEAT  = 3'd4,
    PH_UP      = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    EV_DOWN    = 2'd0,
    EV_LONG    = 2'd1,
    EV_REPEAT  = 2'd2,
    EV_RELEASE = 2'd3
  } event_kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LONG_TICKS   = 2'd0,
    CFG_REPEAT_TICKS = 2'd1,
    CFG_ACTIVE_MASK  = 2'd2
  } cfg_reg_e;

  localparam int unsigned CountW   = 16;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CountW-1:0] LongTicksReset   = 16'd200;
  localparam logic [CountW-1:0] RepeatTicksReset = 16'd40;
  localparam logic [MaskW-1:0]  ActiveMaskReset  = 8'd0;
  localparam logic [CountW-1:0] CountMax         = 16'hFFFF;

  // One entry of the per-key state memory.
  typedef struct packed {
    phase_e              phase;
    logic [CountW-1:0]   count;
  } key_entry_t;

  localparam key_entry_t EntryReset = '{phase: PH_START, count: '0};

  typedef struct packed {
    logic        valid;
    event_kind_e kind;
  } key_event_t;

endpackage

/* hdl/kdlpr_step.sv */
// Next-state and event logic for one key sample (combinational).
// Depends on kdlpr_pkg for the entry and event types.
module kdlpr_step (
  input  kdlpr_pkg::key_entry_t         entry_i,
  input  logic                          pressed_i,
  input  logic [kdlpr_pkg::CountW-1:0]  hold_limit_i,
  input  logic [kdlpr_pkg::CountW-1:0]  repeat_ticks_i,
  output kdlpr_pkg::key_entry_t         entry_o,
  output kdlpr_pkg::key_event_t         event_o
);

  logic [kdlpr_pkg::CountW-1:0] bumped;

  // saturating hold counter
  assign bumped = (entry_i.count == kdlpr_pkg::CountMax) ? entry_i.count
                                                         : entry_i.count + 1'b1;

  always_comb begin
    entry_o       = entry_i;
    event_o.valid = 1'b0;
    event_o.kind  = kdlpr_pkg::EV_DOWN;
    unique case (entry_i.phase)
      kdlpr_pkg::PH_CONFIRM: begin
        entry_o.phase = pressed_i ? kdlpr_pkg::PH_DOWN : kdlpr_pkg::PH_START;
      end
      kdlpr_pkg::PH_DOWN: begin
        if (pressed_i) begin
          entry_o.count = '0;
          entry_o.phase = kdlpr_pkg::PH_LONG;
          event_o.valid = 1'b1;
          event_o.kind  = kdlpr_pkg::EV_DOWN;
        end else begin
          entry_o.phase = kdlpr_pkg::PH_UP;
        end
      end
      kdlpr_pkg::PH_LONG: begin
        if (pressed_i) begin
          entry_o.count = bumped;
          if (bumped > hold_limit_i) begin
            entry_o.count = '0;
            entry_o.phase = kdlpr_pkg::PH_REPEAT;
            event_o.valid = 1'b1;
            event_o.kind  = kdlpr_pkg::EV_LONG;
          end
        end else begin
          entry_o.phase = kdlpr_pkg::PH_UP;
        end
      end
      kdlpr_pkg::PH_REPEAT: begin
        if (pressed_i) begin
          entry_o.count = bumped;
          if (bumped > repeat_ticks_i) begin
            entry_o.count = '0;
            event_o.valid = 1'b1;
            event_o.kind  = kdlpr_pkg::EV_REPEAT;
          end
        end else begin
          entry_o.phase = kdlpr_pkg::PH_UP;
        end
      end
      kdlpr_pkg::PH_UP: begin
        if (!pressed_i) begin
          entry_o.phase = kdlpr_pkg::PH_START;
          event_o.valid = 1'b1;
          event_o.kind  = kdlpr_pkg::EV_RELEASE;
        end
      end
      default: begin
        // start, and the unused codes
        entry_o.phase = pressed_i ? kdlpr_pkg::PH_CONFIRM : kdlpr_pkg::PH_START;
      end
    endcase
  end

endmodule

/* hdl/key_debounce_long_press_repeat.sv */
// Top level of the key debounce / long press / auto repeat block.
// Depends on kdlpr_pkg and kdlpr_step.
//
// Each input item is one tick sample of one key: a key index and its pin level. The block
// keeps a phase and a 16-bit hold counter per key in a small synchronous state memory and
// emits at most one event item per sample: press down, long press, repeat or release. A
// key is pressed while its level differs from its bit in the active-level mask. The block
// takes one item per clock for any mix of keys unless the output stalls. Each item reads
// its key's entry via the state memory's registered port, then updates it, writes it back
// and loads the event into the output register. Samples of the same key on consecutive
// cycles are handled by bypassing the entry just written to the following read. Key
// indexes at or above NUM_KEYS are dropped without an event. Per-key valid flops make
// every entry read as "start, count zero" after reset, so no clearing pass is needed.
// Configuration must be written via the cfg port while idle; this is not enforced.
module key_debounce_long_press_repeat #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] key_index, [3] sampled level, [7:4] zero
  // event items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] event_key, [7:3] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [kdlpr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kdlpr_pkg::CountW-1:0]  cfg_data_i
);

  localparam int unsigned AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned KW = (AW > kdlpr_pkg::KeyW) ? AW : kdlpr_pkg::KeyW;

  // ---------------------------------------------------------------- config
  logic [kdlpr_pkg::CountW-1:0] hold_limit_q, hold_limit_d;
  logic [kdlpr_pkg::CountW-1:0] repeat_ticks_q, repeat_ticks_d;
  logic [kdlpr_pkg::MaskW-1:0]  active_mask_q, active_mask_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    hold_limit_d   = hold_limit_q;
    repeat_ticks_d = repeat_ticks_q;
    active_mask_d  = active_mask_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kdlpr_pkg::CFG_LONG_TICKS:   hold_limit_d   = cfg_data_i;
        kdlpr_pkg::CFG_REPEAT_TICKS: repeat_ticks_d = cfg_data_i;
        kdlpr_pkg::CFG_ACTIVE_MASK:  active_mask_d  = cfg_data_i[kdlpr_pkg::MaskW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_limit_q   <= kdlpr_pkg::LongTicksReset;
      repeat_ticks_q <= kdlpr_pkg::RepeatTicksReset;
      active_mask_q  <= kdlpr_pkg::ActiveMaskReset;
    end else begin
      hold_limit_q   <= hold_limit_d;
      repeat_ticks_q <= repeat_ticks_d;
      active_mask_q  <= active_mask_d;
    end
  end

  // ---------------------------------------------------------------- stage 0: accept, read
  logic                         in_acc;
  logic [KW-1:0]                in_key_wide;
  logic [AW-1:0]                in_addr;
  logic                         in_range;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign in_key_wide = KW'(s_axis_tdata[kdlpr_pkg::KeyW-1:0]);
  assign in_addr     = in_key_wide[AW-1:0];
  assign in_range    = {1'b0, in_key_wide} < (KW+1)'(NUM_KEYS);

  // ---------------------------------------------------------------- stage 1 registers
  logic                           s1_valid_q;
  logic [AW-1:0]                  s1_addr_q;
  logic [kdlpr_pkg::KeyW-1:0]     s1_key_q;
  logic                           s1_level_q;
  logic                           s1_range_q;
  logic                           byp_sel_q;
  kdlpr_pkg::key_entry_t          byp_q;
  kdlpr_pkg::key_entry_t          rdata_q;
  logic [NUM_KEYS-1:0]            vld_q;

  kdlpr_pkg::key_entry_t          key_mem [NUM_KEYS];

  kdlpr_pkg::key_entry_t          cur_entry;
  kdlpr_pkg::key_entry_t          nxt_entry;
  kdlpr_pkg::key_event_t          step_ev;
  logic                           pressed;
  logic                           out_free;
  logic                           s1_fire;
  logic                           mem_wr;

  // output register is free next cycle if empty or being drained now
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign mem_wr        = s1_fire && s1_range_q;

  // entry just written wins over the stale memory read; never-written keys read as reset
  always_comb begin
    if (byp_sel_q) begin
      cur_entry = byp_q;
    end else if (vld_q[s1_addr_q]) begin
      cur_entry = rdata_q;
    end else begin
      cur_entry = kdlpr_pkg::EntryReset;
    end
  end

  assign pressed = s1_level_q != active_mask_q[s1_key_q];

  kdlpr_step u_step (
    .entry_i        (cur_entry),
    .pressed_i      (pressed),
    .hold_limit_i   (hold_limit_q),
    .repeat_ticks_i (repeat_ticks_q),
    .entry_o        (nxt_entry),
    .event_o        (step_ev)
  );

  // state memory: one write port (stage 1), one registered read port (stage 0)
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      key_mem[s1_addr_q] <= nxt_entry;
    end
    if (in_acc) begin
      rdata_q <= key_mem[in_addr];
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q  <= in_addr;
      s1_key_q   <= s_axis_tdata[kdlpr_pkg::KeyW-1:0];
      s1_level_q <= s_axis_tdata[kdlpr_pkg::KeyW];
      s1_range_q <= in_range;
      byp_q      <= nxt_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_sel_q  <= 1'b0;
      vld_q      <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        // same key written at this very edge: read sees old data, so forward
        byp_sel_q  <= mem_wr && (s1_addr_q == in_addr);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (mem_wr) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- output register
  logic                        out_valid_q;
  logic [kdlpr_pkg::KeyW-1:0]  out_key_q;
  kdlpr_pkg::event_kind_e      out_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= step_ev.valid && s1_range_q;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_key_q  <= s1_key_q;
      out_kind_q <= step_ev.kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - kdlpr_pkg::KeyW){1'b0}}, out_key_q};
  assign m_axis_tuser  = out_kind_q;

endmodule
